// ===== rtl/core/u8scf_pkg.sv =====
package u8scf_pkg;

   // ASCII punctuation that ends a sentence.
   localparam logic [7:0] CHR_DOT      = 8'h2E;
   localparam logic [7:0] CHR_BANG     = 8'h21;
   localparam logic [7:0] CHR_QUERY    = 8'h3F;

   // ASCII letter ranges and the case offset.
   localparam logic [7:0] CHR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CHR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // UTF-8 lead byte classes.
   localparam logic [7:0] ASCII_MASK   = 8'h80;
   localparam logic [7:0] LEAD_MASK    = 8'hE0;
   localparam logic [7:0] LEAD_2BYTE   = 8'hC0;
   localparam logic [7:0] CYR_LEAD_D0  = 8'hD0;
   localparam logic [7:0] CYR_LEAD_D1  = 8'hD1;

   // Cyrillic continuation byte ranges.
   localparam logic [7:0] CYR_D1_LO    = 8'h80;
   localparam logic [7:0] CYR_D1_HI    = 8'h8F;
   localparam logic [7:0] CYR_CAP_LO   = 8'h90;
   localparam logic [7:0] CYR_CAP_MID  = 8'h9F;
   localparam logic [7:0] CYR_CAP_HI2  = 8'hA0;
   localparam logic [7:0] CYR_CAP_HI   = 8'hAF;
   localparam logic [7:0] CYR_SML_LO   = 8'hB0;
   localparam logic [7:0] CYR_SML_HI   = 8'hBF;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Results produced by one accepted request, handed to the queue.
   typedef struct packed {
      logic       push_one;
      logic       push_two;
      logic [7:0] data0;
      logic       last0;
      logic [7:0] data1;
      logic       last1;
   } u8scf_push_type;

   // One queued result.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } u8scf_entry_type;

endpackage

// ===== rtl/core/u8scf_if.sv =====
// Request channel: one raw byte of the line per request.
interface u8scf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel: one corrected byte per transfer.
interface u8scf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/u8scf_case_logic.sv =====
module u8scf_case_logic
   import u8scf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output u8scf_push_type push
);

   logic       sentence_ff, sentence_in;
   logic       pending_ff, pending_in;
   logic [7:0] held_ff, held_in;

   // Decode and correct the incoming byte against the held lead byte.
   always_comb begin
      logic [7:0] first;
      logic [7:0] second;
      logic       is_punct;
      logic       is_lead;
      first       = held_ff;
      second      = in_byte;
      is_punct    = (in_byte == CHR_DOT) || (in_byte == CHR_BANG) || (in_byte == CHR_QUERY);
      is_lead     = ((in_byte & LEAD_MASK) == LEAD_2BYTE);
      sentence_in = sentence_ff;
      pending_in  = pending_ff;
      held_in     = held_ff;
      push        = '0;

      if (pending_ff) begin
         // Second byte of a two byte character: fix the pair and emit both.
         if (sentence_ff) begin
            if (held_ff == CYR_LEAD_D0 && in_byte >= CYR_SML_LO && in_byte <= CYR_SML_HI) begin
               second      = in_byte - CASE_OFFSET;
               sentence_in = 1'b0;
            end else if (held_ff == CYR_LEAD_D1 && in_byte >= CYR_D1_LO
                         && in_byte <= CYR_D1_HI) begin
               first       = CYR_LEAD_D0;
               second      = in_byte + CASE_OFFSET;
               sentence_in = 1'b0;
            end else if (held_ff == CYR_LEAD_D0 && in_byte >= CYR_CAP_LO
                         && in_byte <= CYR_CAP_HI) begin
               sentence_in = 1'b0;
            end
         end else begin
            if (held_ff == CYR_LEAD_D0 && in_byte >= CYR_CAP_LO && in_byte <= CYR_CAP_MID) begin
               second = in_byte + CASE_OFFSET;
            end else if (held_ff == CYR_LEAD_D0 && in_byte >= CYR_CAP_HI2
                         && in_byte <= CYR_CAP_HI) begin
               first  = CYR_LEAD_D1;
               second = in_byte - CASE_OFFSET;
            end
         end
         pending_in    = 1'b0;
         push.push_two = 1'b1;
         push.data0    = first;
         push.last0    = 1'b0;
         push.data1    = second;
         push.last1    = in_last;
      end else if (is_punct) begin
         // Sentence punctuation re-arms capitalisation.
         sentence_in   = 1'b1;
         push.push_one = 1'b1;
         push.data0    = in_byte;
         push.last0    = in_last;
      end else if (is_lead && !in_last) begin
         // Hold a lead byte until its partner arrives.
         held_in    = in_byte;
         pending_in = 1'b1;
      end else begin
         // Single byte: capitalise an ASCII letter at sentence start.
         push.push_one = 1'b1;
         push.data0    = in_byte;
         push.last0    = in_last;
         if (sentence_ff && ((in_byte & ASCII_MASK) == 8'h00)) begin
            if (in_byte >= CHR_LOWER_A && in_byte <= CHR_LOWER_Z) begin
               push.data0  = in_byte - CASE_OFFSET;
               sentence_in = 1'b0;
            end else if (in_byte >= CHR_UPPER_A && in_byte <= CHR_UPPER_Z) begin
               sentence_in = 1'b0;
            end
         end
      end

      // The end of a line restarts the sentence and drops any held byte.
      if (in_last) begin
         sentence_in = 1'b1;
         pending_in  = 1'b0;
      end

      if (!accept) begin
         push = '0;
      end
   end

   // Sentence and lead byte state, updated on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         sentence_ff <= 1'b1;
         pending_ff  <= 1'b0;
         held_ff     <= 8'h00;
      end else if (accept) begin
         sentence_ff <= sentence_in;
         pending_ff  <= pending_in;
         held_ff     <= held_in;
      end
   end

endmodule

// ===== rtl/core/u8scf_out_queue.sv =====
module u8scf_out_queue
   import u8scf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  u8scf_push_type push,
   output logic           has_room,
   u8scf_rsp_if.source    rsp_ch
);

   localparam logic [QUEUE_AW:0] COUNT_LIMIT = (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);

   u8scf_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      pop;
   logic [QUEUE_AW:0]         n_push;
   logic [QUEUE_AW-1:0]       wr_next;

   // Room for a full pair is needed before a new request is taken.
   assign has_room        = (count_ff <= COUNT_LIMIT);
   assign rsp_ch.valid    = (count_ff != '0);
   assign rsp_ch.out_byte = slot_ff[rd_ptr_ff].data;
   assign rsp_ch.out_last = slot_ff[rd_ptr_ff].last;
   assign pop             = rsp_ch.valid && rsp_ch.ready;
   assign wr_next         = wr_ptr_ff + 1'b1;

   // Pointer and count arithmetic.
   always_comb begin
      n_push = '0;
      if (push.push_two) begin
         n_push = (QUEUE_AW + 1)'(2);
      end else if (push.push_one) begin
         n_push = (QUEUE_AW + 1)'(1);
      end
      wr_ptr_in = wr_ptr_ff + n_push[QUEUE_AW-1:0];
      rd_ptr_in = rd_ptr_ff + {{(QUEUE_AW-1){1'b0}}, pop};
      count_in  = count_ff + n_push - {{QUEUE_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage: up to two entries are written per cycle.
   always_ff @(posedge clock) begin
      if (push.push_one || push.push_two) begin
         slot_ff[wr_ptr_ff] <= '{data: push.data0, last: push.last0};
      end
      if (push.push_two) begin
         slot_ff[wr_next] <= '{data: push.data1, last: push.last1};
      end
   end

endmodule

// ===== rtl/core/utf8_sentence_case_fixer_unit.sv =====
// Results: a request's bytes are written into the result queue when it is
// accepted, both bytes of a two byte character together with its partner.
// Throughput: one request per cycle while the four entry result queue has room
// for a pair, needed before taking a request; one result per cycle while ready.
// Reset: synchronous; clears the queue, drops any held lead byte, arms capitals.
module utf8_sentence_case_fixer_unit
   import u8scf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8scf_req_if.sink   req_ch,
   u8scf_rsp_if.source rsp_ch
);

   u8scf_push_type push;
   logic           has_room;
   logic           accept;

   // A request is taken whenever the queue can hold a pair.
   assign req_ch.ready = has_room;
   assign accept       = req_ch.valid && has_room;

   u8scf_case_logic u_case_logic (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_ch.in_byte),
      .in_last (req_ch.in_last),
      .push    (push)
   );

   u8scf_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .has_room (has_room),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import u8scf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 100;

   logic clock;
   logic reset;

   u8scf_req_if req_ch ();
   u8scf_rsp_if rsp_ch ();

   utf8_sentence_case_fixer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Corrected bytes still to come, oldest first.
   u8scf_entry_type expected_bytes[$];

   // Mirror of the block's case state.
   logic       awaiting_capital;
   logic       lead_waiting;
   logic [7:0] lead_byte;

   int error_count;
   int cycle_count;
   int requests_sent;
   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold_cycles;

   // Free running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit in case the block stops answering.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   task automatic push_expected(input logic [7:0] data, input logic last);
      u8scf_entry_type entry;
      entry.data = data;
      entry.last = last;
      expected_bytes.push_back(entry);
   endtask

   // Works out the corrected bytes that one accepted request gives.
   task automatic predict_corrected_bytes(input logic [7:0] b, input logic last);
      logic [7:0] first;
      logic [7:0] second;
      if (lead_waiting) begin
         first  = lead_byte;
         second = b;
         if (awaiting_capital) begin
            if (first == CYR_LEAD_D0 && second >= CYR_SML_LO && second <= CYR_SML_HI) begin
               second           = second - CASE_OFFSET;
               awaiting_capital = 1'b0;
            end else if (first == CYR_LEAD_D1 && second >= CYR_D1_LO &&
                         second <= CYR_D1_HI) begin
               first            = CYR_LEAD_D0;
               second           = second + CASE_OFFSET;
               awaiting_capital = 1'b0;
            end else if (first == CYR_LEAD_D0 && second >= CYR_CAP_LO &&
                         second <= CYR_CAP_HI) begin
               awaiting_capital = 1'b0;
            end
         end else begin
            if (first == CYR_LEAD_D0 && second >= CYR_CAP_LO && second <= CYR_CAP_MID) begin
               second = second + CASE_OFFSET;
            end else if (first == CYR_LEAD_D0 && second >= CYR_CAP_HI2 &&
                         second <= CYR_CAP_HI) begin
               first  = CYR_LEAD_D1;
               second = second - CASE_OFFSET;
            end
         end
         lead_waiting = 1'b0;
         push_expected(first, 1'b0);
         push_expected(second, last);
      end else if (b == CHR_DOT || b == CHR_BANG || b == CHR_QUERY) begin
         awaiting_capital = 1'b1;
         push_expected(b, last);
      end else if ((b & LEAD_MASK) == LEAD_2BYTE && !last) begin
         lead_byte    = b;
         lead_waiting = 1'b1;
      end else begin
         first = b;
         if (awaiting_capital && (b & ASCII_MASK) == 8'h00) begin
            if (b >= CHR_LOWER_A && b <= CHR_LOWER_Z) begin
               first            = b - CASE_OFFSET;
               awaiting_capital = 1'b0;
            end else if (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) begin
               awaiting_capital = 1'b0;
            end
         end
         push_expected(first, last);
      end
      // The end of a line rearms capitals and drops any held lead byte.
      if (last) begin
         awaiting_capital = 1'b1;
         lead_waiting     = 1'b0;
      end
   endtask

   // Offers one request, after a random gap, and waits for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= last;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      predict_corrected_bytes(b, last);
      requests_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sends one line of mostly well formed text with random content.
   task automatic send_random_line();
      int         n_chars;
      int         kind;
      logic       last_char;
      logic [7:0] lead;
      logic [7:0] tail;
      n_chars = $urandom_range(1, 16);
      for (int i = 0; i < n_chars; i++) begin
         last_char = (i == n_chars - 1);
         kind      = $urandom_range(0, 19);
         if (kind <= 4) begin
            send_byte(8'(CHR_LOWER_A + $urandom_range(0, 25)), last_char);
         end else if (kind <= 6) begin
            send_byte(8'(CHR_UPPER_A + $urandom_range(0, 25)), last_char);
         end else if (kind <= 8) begin
            case ($urandom_range(0, 2))
               0: send_byte(CHR_DOT, last_char);
               1: send_byte(CHR_BANG, last_char);
               default: send_byte(CHR_QUERY, last_char);
            endcase
         end else if (kind <= 10) begin
            if ($urandom_range(0, 1) == 0) begin
               send_byte(8'h20, last_char);
            end else begin
               send_byte(8'(8'h30 + $urandom_range(0, 9)), last_char);
            end
         end else if (kind <= 15) begin
            // Cyrillic letters, plus the neighbours that pass unchanged.
            case ($urandom_range(0, 3))
               0: begin
                  lead = CYR_LEAD_D0;
                  tail = 8'($urandom_range(CYR_SML_LO, CYR_SML_HI));
               end
               1: begin
                  lead = CYR_LEAD_D0;
                  tail = 8'($urandom_range(CYR_CAP_LO, CYR_CAP_HI));
               end
               2: begin
                  lead = CYR_LEAD_D1;
                  tail = 8'($urandom_range(CYR_D1_LO, CYR_D1_HI));
               end
               default: begin
                  lead = 8'($urandom_range(CYR_LEAD_D0, CYR_LEAD_D1));
                  tail = 8'($urandom_range(8'h80, 8'hBF));
               end
            endcase
            send_byte(lead, 1'b0);
            send_byte(tail, last_char);
         end else if (kind == 16) begin
            send_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), last_char);
         end else if (kind == 17) begin
            // A lead byte that closes the line passes on its own.
            send_byte(8'($urandom_range(8'hC0, 8'hDF)), last_char);
            if (!last_char) begin
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end else begin
            send_byte(8'($urandom_range(0, 255)), last_char);
         end
      end
   endtask

   task automatic test_directed();
      logic [8:0] seq [] = '{
         9'h061, 9'h062, 9'h02E, 9'h020, 9'h07A, 9'h021,
         9'h0D0, 9'h0B0, 9'h0D0, 9'h09F, 9'h0D0, 9'h0AF, 9'h03F,
         9'h0D1, 9'h08F, 9'h0D0, 9'h081, 9'h0C3, 9'h02E,
         9'h071, 9'h000, 9'h0FF, 9'h1D0,
         9'h080, 9'h161,
         9'h0D0, 9'h095, 9'h178
      };
      foreach (seq[i]) begin
         send_byte(seq[i][7:0], seq[i][8]);
      end
   endtask

   task automatic test_random_text(input int n_requests, input int tx_pct, input int rx_pct);
      int target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target      = requests_sent + n_requests;
      while (requests_sent < target) begin
         send_random_line();
      end
   endtask

   // The receiver holds off while the sender keeps offering, then the sender
   // pauses until the block has emptied.
   task automatic test_backpressure();
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      rx_hold_cycles = 80;
      repeat (4) send_random_line();
      stop_sending();
      wait_for_results();
      repeat (3) send_random_line();
   endtask

   // Receiver: random ready, or a counted hold-off when one is asked for.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Compares each accepted result with the oldest expected byte.
   always @(posedge clock) begin
      u8scf_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            report_error($sformatf("unexpected result byte %02h last %0b",
                                   rsp_ch.out_byte, rsp_ch.out_last));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.out_byte !== want.data) begin
               report_error($sformatf("out_byte %02h, expected %02h",
                                      rsp_ch.out_byte, want.data));
            end
            if (rsp_ch.out_last !== want.last) begin
               report_error($sformatf("out_last %0b, expected %0b for byte %02h",
                                      rsp_ch.out_last, want.last, want.data));
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.in_byte   = 8'h00;
      req_ch.in_last   = 1'b0;
      error_count      = 0;
      requests_sent    = 0;
      rx_hold_cycles   = 0;
      tx_idle_pct      = 31;
      rx_idle_pct      = 73;
      awaiting_capital = 1'b1;
      lead_waiting     = 1'b0;
      lead_byte        = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_text(600, 31, 73);
      test_random_text(600, 73, 31);
      test_random_text(600, 0, 0);
      test_backpressure();

      stop_sending();
      wait_for_results();
      if (expected_bytes.size() != 0) begin
         report_error($sformatf("%0d result bytes never arrived", expected_bytes.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
